// File: sv/pfrt_pkg.sv
// Shared types and codes for the port forwarding rule table.
// No dependencies; compile before every other file of the block.
`timescale 1ns / 1ps

package pfrt_pkg;

  // Key is protocol (2 bits) over match port (16 bits); target is address over port.
  localparam int unsigned PROTO_W = 2;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned KEY_W   = PROTO_W + PORT_W;
  localparam int unsigned TGT_W   = ADDR_W + PORT_W;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_DEL  = 2'd1,
    MODE_FIND = 2'd2
  } pfrt_mode_e;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_MISS = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;    // write an invalid entry at the slot index
    logic start;     // latch the request beat and clear scan results
    logic rd_en;     // read the key store at the slot index
    logic commit;    // apply the operation to the stores
    logic load_out;  // load the response register
  } pfrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // response register can take a beat this cycle
  } pfrt_sts_t;

endpackage

// File: sv/pfrt_req_if.sv
// Request channel of the port forwarding rule table: valid/ready plus request fields.
// Depends on pfrt_pkg for field widths.
`timescale 1ns / 1ps

interface pfrt_req_if;
  import pfrt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [PROTO_W-1:0]   protocol;
  logic [PORT_W-1:0]    match_port;
  logic [ADDR_W-1:0]    target_addr_in;
  logic [PORT_W-1:0]    target_port_in;

  modport source (
    output valid, mode, protocol, match_port, target_addr_in, target_port_in,
    input  ready
  );

  modport sink (
    input  valid, mode, protocol, match_port, target_addr_in, target_port_in,
    output ready
  );
endinterface

// File: sv/pfrt_rsp_if.sv
// Response channel of the port forwarding rule table: valid/ready plus result fields.
// Depends on pfrt_pkg for field widths.
`timescale 1ns / 1ps

interface pfrt_rsp_if;
  import pfrt_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ADDR_W-1:0]  target_addr;
  logic [PORT_W-1:0]  target_port;

  modport source (
    output valid, status, target_addr, target_port,
    input  ready
  );

  modport sink (
    input  valid, status, target_addr, target_port,
    output ready
  );
endinterface

// File: sv/pfrt_datapath.sv
// Datapath of the port forwarding rule table: key and target stores, scan
// registers, commit logic and response register.
// Depends on pfrt_pkg and both channel interfaces.
`timescale 1ns / 1ps

module pfrt_datapath
  import pfrt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES  = 64,
  parameter int unsigned PROTOCOL_COUNT = 4,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pfrt_cmd_t        cmd_i,
  input  logic [IDX_W-1:0] slot_idx_i,
  output pfrt_sts_t        sts_o,
  pfrt_req_if.sink         req_i,
  pfrt_rsp_if.source       rsp_o
);

  // Key store entry: valid flag over key.
  logic [KEY_W:0]     key_mem [TABLE_ENTRIES];
  logic [TGT_W-1:0]   tgt_mem [TABLE_ENTRIES];

  logic [1:0]         mode_q;
  logic [PROTO_W-1:0] proto_q;
  logic [PORT_W-1:0]  port_q;
  logic [ADDR_W-1:0]  taddr_q;
  logic [PORT_W-1:0]  tport_q;
  logic [KEY_W-1:0]   key;

  logic [KEY_W:0]     rd_q;
  logic               rd_vld_q;
  logic               hit_q, free_q;
  logic [IDX_W-1:0]   hit_idx_q, free_idx_q;

  logic               proto_ok;
  logic               key_wr, tgt_wr, tgt_rd, find_hit_d;
  logic [1:0]         status_d;
  logic [IDX_W-1:0]   wr_idx;
  logic               kw_en;
  logic [IDX_W-1:0]   kw_addr;
  logic [KEY_W:0]     kw_data;

  logic [TGT_W-1:0]   tgt_q;
  logic [1:0]         res_status_q;
  logic               res_hit_q;

  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [PORT_W-1:0]  out_port_q;

  assign key      = {proto_q, port_q};
  assign proto_ok = ({3'b000, proto_q} < 5'(PROTOCOL_COUNT));

  // Hold the request beat for the whole operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q  <= req_i.mode;
      proto_q <= req_i.protocol;
      port_q  <= req_i.match_port;
      taddr_q <= req_i.target_addr_in;
      tport_q <= req_i.target_port_in;
    end
  end

  // Key store read, one entry a cycle during the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= key_mem[slot_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.start) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (rd_vld_q) begin
        if (rd_q[KEY_W] && (rd_q[KEY_W-1:0] == key) && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!rd_q[KEY_W] && !free_q) begin
          free_q <= 1'b1;
        end
      end
    end
  end

  // Index of the entry under evaluation is the read address, registered in step with the read data.
  logic [IDX_W-1:0] rd_idx_q;
  always_ff @(posedge clk_i) begin
    rd_idx_q <= slot_idx_i;
    if (rd_vld_q && !cmd_i.start) begin
      if (rd_q[KEY_W] && (rd_q[KEY_W-1:0] == key) && !hit_q) begin
        hit_idx_q <= rd_idx_q;
      end
      if (!rd_q[KEY_W] && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
  end

  // Decide the operation once the scan is complete.
  always_comb begin
    key_wr     = 1'b0;
    tgt_wr     = 1'b0;
    tgt_rd     = 1'b0;
    find_hit_d = 1'b0;
    status_d   = STS_MISS;
    wr_idx     = hit_idx_q;
    if (proto_ok) begin
      case (pfrt_mode_e'(mode_q))
        MODE_ADD: begin
          if (hit_q) begin
            key_wr   = 1'b1;
            tgt_wr   = 1'b1;
            status_d = STS_OK;
          end else if (free_q) begin
            key_wr   = 1'b1;
            tgt_wr   = 1'b1;
            wr_idx   = free_idx_q;
            status_d = STS_OK;
          end else begin
            status_d = STS_FULL;
          end
        end
        MODE_DEL: begin
          if (hit_q) begin
            key_wr   = 1'b1;
            status_d = STS_OK;
          end
        end
        MODE_FIND: begin
          if (hit_q) begin
            tgt_rd     = 1'b1;
            find_hit_d = 1'b1;
            status_d   = STS_OK;
          end
        end
        default: begin
          status_d = STS_MISS;
        end
      endcase
    end
  end

  assign kw_en   = cmd_i.clr_wr | (cmd_i.commit & key_wr);
  assign kw_addr = cmd_i.clr_wr ? slot_idx_i : wr_idx;
  assign kw_data = cmd_i.clr_wr ? '0
                 : {(pfrt_mode_e'(mode_q) == MODE_ADD), key};

  always_ff @(posedge clk_i) begin
    if (kw_en) begin
      key_mem[kw_addr] <= kw_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && tgt_wr) begin
      tgt_mem[wr_idx] <= {taddr_q, tport_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && tgt_rd) begin
      tgt_q <= tgt_mem[hit_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_status_q <= status_d;
      res_hit_q    <= find_hit_d;
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_hit_q ? tgt_q[TGT_W-1:PORT_W] : '0;
      out_port_q   <= res_hit_q ? tgt_q[PORT_W-1:0] : '0;
    end
  end

  assign sts_o.out_free  = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.target_addr = out_addr_q;
  assign rsp_o.target_port = out_port_q;

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> sts_o.out_free)
    else $error("response loaded over an unaccepted beat");

  a_load_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("response register not valid after load");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_status_q == STS_OK || out_status_q == STS_MISS
                     || out_status_q == STS_FULL))
    else $error("response carries an unknown status code");

endmodule

// File: sv/pfrt_ctrl.sv
// Controller of the port forwarding rule table: clearing pass, scan sequencing,
// commit and response hand-off. Depends on pfrt_pkg.
`timescale 1ns / 1ps

module pfrt_ctrl
  import pfrt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  pfrt_sts_t        sts_i,
  output pfrt_cmd_t        cmd_o,
  output logic [IDX_W-1:0] slot_idx_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESULT
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_e           state_q;
  logic [IDX_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (cnt_q == LAST_IDX) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (req_valid_i) begin
            cnt_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_q == LAST_IDX) begin
            cnt_q   <= '0;
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_CLEAR;
          cnt_q   <= '0;
        end
      endcase
    end
  end

  assign req_ready_o     = (state_q == ST_IDLE);
  assign slot_idx_o      = cnt_q;
  assign cmd_o.clr_wr    = (state_q == ST_CLEAR);
  assign cmd_o.start     = (state_q == ST_IDLE) && req_valid_i;
  assign cmd_o.rd_en     = (state_q == ST_SCAN);
  assign cmd_o.commit    = (state_q == ST_COMMIT);
  assign cmd_o.load_out  = (state_q == ST_RESULT) && sts_i.out_free;

  a_scan_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cnt_q == LAST_IDX) |=> state_q == ST_DRAIN)
    else $error("scan did not end after the last slot");

  a_commit_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> (state_q == ST_RESULT && !cmd_o.commit))
    else $error("commit not followed by result");

  a_start_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == ST_SCAN && cnt_q == '0))
    else $error("scan did not start at slot zero");

endmodule

// File: sv/port_forward_rule_table.sv
// One request beat at a time: the next is accepted only after the previous response is loaded,
//   and each takes a full scan of the key store, which has one read port and visits one slot
//   a cycle; a stalled response holds back the next request beat as well.
// Reset: asynchronous, active low; afterwards a clearing pass over all TABLE_ENTRIES slots marks
//   every slot free, and no request beat is accepted until it ends.
// Depends on pfrt_pkg, pfrt_req_if, pfrt_rsp_if, pfrt_datapath and pfrt_ctrl.
`timescale 1ns / 1ps

module port_forward_rule_table
  import pfrt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES  = 64,
  parameter int unsigned PROTOCOL_COUNT = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfrt_req_if.sink   req_i,
  pfrt_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  // Command and status between the sequencer and the storage/compare datapath.
  pfrt_cmd_t        cmd;
  pfrt_sts_t        sts;
  logic [IDX_W-1:0] slot_idx;
  logic             ctrl_ready;

  // The sequencer walks: clear pass, then per request beat a full scan of the key store
  // (recording the first matching slot and the lowest free slot), a drain state for
  // the last registered read, a commit state that writes or reads the stores, and a
  // result state that waits for the response register to free up.
  pfrt_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (ctrl_ready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .slot_idx_o  (slot_idx)
  );

  // Memories, scan results, commit decision and the response register live here.
  pfrt_datapath #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .PROTOCOL_COUNT (PROTOCOL_COUNT)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .slot_idx_i (slot_idx),
    .sts_o      (sts),
    .req_i      (req_i),
    .rsp_o      (rsp_o)
  );

  // Ready comes from the sequencer: high only while it waits for a request beat.
  assign req_i.ready = ctrl_ready;

endmodule
